// ----- rtl/lirs_pkg.sv -----
`default_nettype none
package lirs_pkg;

    // Block table geometry: one entry per block number, links carry one extra null code
    localparam int NUM_BLOCKS = 65536;
    localparam int ADDR_W     = $clog2(NUM_BLOCKS);
    localparam int LINK_W     = ADDR_W + 1;
    localparam int BLK_W      = 16;
    localparam int CNT_W      = 17;
    localparam int HIR_W      = 16;

    typedef logic [LINK_W-1:0] link_t;

    localparam link_t NIL_LINK = LINK_W'(NUM_BLOCKS);

    // Per-block entry kept in the table memory
    typedef struct packed {
        logic  res;
        logic  hir;
        logic  instk;
        link_t sprev;
        link_t snext;
        link_t qprev;
        link_t qnext;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    localparam entry_t ENTRY_RESET = '{
        res:   1'b0,
        hir:   1'b1,
        instk: 1'b0,
        sprev: NIL_LINK,
        snext: NIL_LINK,
        qprev: NIL_LINK,
        qnext: NIL_LINK
    };

    // Link fields touched by a single neighbor edit
    typedef enum logic [1:0] {
        FLD_SPREV,
        FLD_SNEXT,
        FLD_QPREV,
        FLD_QNEXT
    } field_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_CACHE_SIZE = 2'd0,
        REG_HIR_LIMIT  = 2'd1,
        REG_MAX_STACK  = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [CNT_W-1:0] cache_size;
        logic [HIR_W-1:0] hir_limit;
        logic [CNT_W-1:0] max_stack_len;
    } cfg_t;

    typedef struct packed {
        logic             hit;
        logic             evicted_valid;
        logic [BLK_W-1:0] evicted_block;
        logic [CNT_W-1:0] stack_length;
        logic [CNT_W-1:0] lir_count;
    } result_t;

    function automatic logic [ADDR_W-1:0] to_addr(input link_t l);
        return l[ADDR_W-1:0];
    endfunction

    function automatic entry_t set_link(input entry_t e, input field_t f, input link_t v);
        entry_t r;
        r = e;
        unique case (f)
            FLD_SPREV: r.sprev = v;
            FLD_SNEXT: r.snext = v;
            FLD_QPREV: r.qprev = v;
            FLD_QNEXT: r.qnext = v;
            default:   r = e;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/lirs_cache_replacement.sv -----
// A repeat of the previous block is answered from the idle state without a table access;
// a miss or hit is paced by the single table memory port: each linked-entry edit is a
// read then a write of one entry, and each entry visited on bottom-LIR and prune walks
// adds a table read. Throughput: one block at a time; the next beat is taken while
// one result waits in the output register.
// Reset (aresetn low, synchronous) and any write to registers 0..2 start a table
// sweep over all 65536 entries, during which no input beat is taken.
`default_nettype none
module lirs_cache_replacement
    import lirs_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration write port
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [16:0] cfg_wdata,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,  // block_number[15:0]
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata   // hit[0], evicted_valid[1], evicted_block[17:2],
                                       // stack_length[34:18], lir_count[51:35], zero[55:52]
);

    cfg_t    cfg_reg;
    logic    restart;
    logic    res_valid, res_ready;
    result_t res;
    logic    m_tvalid_reg;
    logic [55:0] m_tdata_reg;

    // Hold configuration; a known register write restarts the run
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.cache_size    <= CNT_W'(1024);
            cfg_reg.hir_limit     <= HIR_W'(10);
            cfg_reg.max_stack_len <= CNT_W'(65536);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_CACHE_SIZE: cfg_reg.cache_size    <= cfg_wdata;
                REG_HIR_LIMIT:  cfg_reg.hir_limit     <= cfg_wdata[HIR_W-1:0];
                REG_MAX_STACK:  cfg_reg.max_stack_len <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign restart = cfg_wr_en && ((cfg_index == REG_CACHE_SIZE)
                                || (cfg_index == REG_HIR_LIMIT)
                                || (cfg_index == REG_MAX_STACK));

    lirs_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .restart   (restart),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_block  (s_tdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Output register: load a result beat when empty or being drained
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            m_tdata_reg <= {4'b0000, res.lir_count, res.stack_length,
                            res.evicted_block, res.evicted_valid, res.hit};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
`default_nettype wire

// ----- rtl/lirs_ram.sv -----
`default_nettype none
module lirs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one port, read the other with a registered output
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ----- rtl/lirs_ctrl.sv -----
`default_nettype none
module lirs_ctrl
    import lirs_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             restart,
    input  wire cfg_t             cfg,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [BLK_W-1:0] in_block,
    output logic                  res_valid,
    input  wire logic             res_ready,
    output result_t               res
);

    typedef enum logic [5:0] {
        ST_CLEAR, ST_IDLE, ST_DECIDE, ST_EV1,
        ST_SUB, ST_SUB2, ST_PUSH, ST_FLAGS, ST_WB,
        ST_DEM0, ST_DEM1, ST_DEM2, ST_DEM3, ST_DEM4,
        ST_PRUNE, ST_PW0, ST_PW1, ST_PI0, ST_PI1, ST_PI2,
        ST_ED0, ST_ED1, ST_QU0, ST_QU1, ST_SU0, ST_SU1,
        ST_SK0, ST_SK1, ST_FIN
    } state_t;

    state_t state_reg, ed_ret_reg, qu_ret_reg, su_ret_reg, sk_ret_reg;

    link_t  ed_addr_reg, ed_val_reg;
    field_t ed_fld_reg;
    link_t  u_p_reg, u_n_reg, v_p_reg, v_n_reg, sk_p_reg;
    link_t  b_reg, t_reg, pn_reg, qh_reg;
    entry_t rb_reg, tr_reg;
    logic   demote_reg, qh_do_reg;
    logic [ADDR_W:0] clr_cnt_reg;

    link_t  top_reg, bottom_reg, head_reg, tail_reg, bl_reg, last_reg;
    logic [CNT_W-1:0] free_reg, lir_reg, len_reg;

    logic             hit_reg, evv_reg;
    logic [BLK_W-1:0] evb_reg;

    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr, ram_raddr;
    entry_t               ram_wdata;
    logic [ENTRY_W-1:0]   ram_rdata;
    entry_t               rd;

    logic [CNT_W-1:0]     lir_limit;
    logic [CNT_W:0]       lir_inc;
    link_t                in_link;

    assign rd        = entry_t'(ram_rdata);
    assign in_link   = LINK_W'(in_block);
    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_FIN);
    assign lir_inc   = {1'b0, lir_reg} + 1'b1;
    assign lir_limit = (cfg.cache_size > CNT_W'(cfg.hir_limit))
                     ? cfg.cache_size - CNT_W'(cfg.hir_limit) : '0;

    assign res.hit           = hit_reg;
    assign res.evicted_valid = evv_reg;
    assign res.evicted_block = evb_reg;
    assign res.stack_length  = len_reg;
    assign res.lir_count     = lir_reg;

    lirs_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(NUM_BLOCKS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Pick the table read address and the write beat for each step
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = ENTRY_RESET;
        ram_raddr = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg[ADDR_W-1:0];
            end
            ST_IDLE:   ram_raddr = to_addr(in_link);
            ST_DECIDE: ram_raddr = to_addr(tail_reg);
            ST_EV1: begin
                ram_we    = 1'b1;
                ram_waddr = to_addr(t_reg);
                ram_wdata = rd;
                ram_wdata.res = 1'b0;
                if (!((head_reg != t_reg) && (rd.qprev == NIL_LINK))) begin
                    ram_wdata.qprev = NIL_LINK;
                    ram_wdata.qnext = NIL_LINK;
                end
            end
            ST_WB: begin
                ram_we    = 1'b1;
                ram_waddr = to_addr(b_reg);
                ram_wdata = rb_reg;
            end
            ST_DEM0: ram_raddr = to_addr(bl_reg);
            ST_DEM2: begin
                ram_we    = 1'b1;
                ram_waddr = to_addr(t_reg);
                ram_wdata = tr_reg;
                ram_wdata.qprev = NIL_LINK;
                ram_wdata.qnext = head_reg;
                ram_wdata.hir   = 1'b1;
            end
            ST_PW0: ram_raddr = to_addr(t_reg);
            ST_PI0: ram_raddr = to_addr(bl_reg);
            ST_PI1: begin
                ram_we    = 1'b1;
                ram_waddr = to_addr(bl_reg);
                ram_wdata = rd;
                ram_wdata.snext = t_reg;
            end
            ST_PI2: begin
                ram_we    = 1'b1;
                ram_waddr = to_addr(t_reg);
                ram_wdata = tr_reg;
                ram_wdata.instk = 1'b0;
                ram_wdata.sprev = bl_reg;
                ram_wdata.snext = pn_reg;
            end
            ST_ED0: ram_raddr = to_addr(ed_addr_reg);
            ST_ED1: begin
                ram_we    = 1'b1;
                ram_waddr = to_addr(ed_addr_reg);
                ram_wdata = set_link(rd, ed_fld_reg, ed_val_reg);
            end
            ST_SK0: ram_raddr = to_addr(sk_p_reg);
            ST_SK1: begin
                ram_we    = rd.hir && rd.instk;
                ram_waddr = to_addr(sk_p_reg);
                ram_wdata = rd;
                ram_wdata.instk = 1'b0;
            end
            default: ;
        endcase
    end

    // Sequencer: state, list ends, counters and result
    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            top_reg     <= NIL_LINK;
            bottom_reg  <= NIL_LINK;
            head_reg    <= NIL_LINK;
            tail_reg    <= NIL_LINK;
            bl_reg      <= NIL_LINK;
            last_reg    <= NIL_LINK;
            free_reg    <= cfg.cache_size;
            lir_reg     <= '0;
            len_reg     <= '0;
            hit_reg     <= 1'b0;
            evv_reg     <= 1'b0;
            evb_reg     <= '0;
            demote_reg  <= 1'b0;
            qh_do_reg   <= 1'b0;
        end else begin
            unique case (state_reg)
                // Sweep the table back to its reset entry
                ST_CLEAR: begin
                    free_reg    <= cfg.cache_size;
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == (ADDR_W+1)'(NUM_BLOCKS - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (in_valid) begin
                        b_reg   <= in_link;
                        hit_reg <= 1'b0;
                        evv_reg <= 1'b0;
                        evb_reg <= '0;
                        if (in_link >= NIL_LINK) begin
                            state_reg <= ST_FIN;
                        end else if (last_reg == in_link) begin
                            hit_reg   <= 1'b1;
                            state_reg <= ST_FIN;
                        end else begin
                            state_reg <= ST_DECIDE;
                        end
                    end
                end
                // Entry of the referenced block is on the read port
                ST_DECIDE: begin
                    rb_reg <= rd;
                    if (!rd.res && (free_reg == '0) && (tail_reg == NIL_LINK)) begin
                        state_reg <= ST_FIN;
                    end else begin
                        last_reg <= b_reg;
                        if (!rd.res) begin
                            if (free_reg == '0) begin
                                t_reg     <= tail_reg;
                                state_reg <= ST_EV1;
                            end else begin
                                free_reg <= free_reg - 1'b1;
                                if (free_reg > CNT_W'(cfg.hir_limit)) begin
                                    rb_reg.hir <= 1'b0;
                                    lir_reg    <= lir_reg + 1'b1;
                                end
                                state_reg <= ST_SUB;
                            end
                        end else begin
                            hit_reg <= 1'b1;
                            if (rd.hir && !((head_reg != b_reg) && (rd.qprev == NIL_LINK))) begin
                                rb_reg.qprev <= NIL_LINK;
                                rb_reg.qnext <= NIL_LINK;
                                u_p_reg      <= rd.qprev;
                                u_n_reg      <= rd.qnext;
                                qu_ret_reg   <= ST_SUB;
                                state_reg    <= ST_QU0;
                            end else begin
                                state_reg <= ST_SUB;
                            end
                        end
                    end
                end
                // Evict the queue tail; the slot count nets out
                ST_EV1: begin
                    evv_reg <= 1'b1;
                    evb_reg <= BLK_W'(t_reg);
                    if ((head_reg != t_reg) && (rd.qprev == NIL_LINK)) begin
                        state_reg <= ST_SUB;
                    end else begin
                        u_p_reg    <= rd.qprev;
                        u_n_reg    <= rd.qnext;
                        qu_ret_reg <= ST_SUB;
                        state_reg  <= ST_QU0;
                    end
                end
                // Take the block out of the stack
                ST_SUB: begin
                    if ((top_reg != b_reg) && (rb_reg.sprev == NIL_LINK)) begin
                        state_reg <= ST_PUSH;
                    end else if (bl_reg == b_reg) begin
                        sk_p_reg   <= rb_reg.sprev;
                        sk_ret_reg <= ST_SUB2;
                        state_reg  <= ST_SK0;
                    end else begin
                        state_reg <= ST_SUB2;
                    end
                end
                ST_SUB2: begin
                    v_p_reg    <= rb_reg.sprev;
                    v_n_reg    <= rb_reg.snext;
                    su_ret_reg <= ST_PUSH;
                    state_reg  <= ST_SU0;
                end
                ST_PUSH: begin
                    rb_reg.sprev <= NIL_LINK;
                    rb_reg.snext <= top_reg;
                    top_reg      <= b_reg;
                    if (top_reg == NIL_LINK) begin
                        bottom_reg <= b_reg;
                        state_reg  <= ST_FLAGS;
                    end else begin
                        ed_addr_reg <= top_reg;
                        ed_fld_reg  <= FLD_SPREV;
                        ed_val_reg  <= b_reg;
                        ed_ret_reg  <= ST_FLAGS;
                        state_reg   <= ST_ED0;
                    end
                end
                // Update marks, promote a stacked HIR block or queue an unstacked HIR block
                ST_FLAGS: begin
                    rb_reg.res   <= 1'b1;
                    rb_reg.instk <= 1'b1;
                    demote_reg   <= 1'b0;
                    qh_do_reg    <= 1'b0;
                    if (!rb_reg.instk) begin
                        len_reg <= len_reg + 1'b1;
                    end
                    if ((bl_reg == NIL_LINK) && !rb_reg.hir) begin
                        bl_reg <= b_reg;
                    end
                    if (rb_reg.hir && rb_reg.instk) begin
                        rb_reg.hir <= 1'b0;
                        if ((lir_inc > {1'b0, lir_limit}) && (bl_reg != NIL_LINK)
                                && (bl_reg != b_reg)) begin
                            demote_reg <= 1'b1;
                        end else begin
                            lir_reg <= lir_inc[CNT_W-1:0];
                            if (bl_reg == NIL_LINK) begin
                                bl_reg <= b_reg;
                            end
                        end
                    end else if (rb_reg.hir) begin
                        rb_reg.qprev <= NIL_LINK;
                        rb_reg.qnext <= head_reg;
                        head_reg     <= b_reg;
                        if (head_reg == NIL_LINK) begin
                            tail_reg <= b_reg;
                        end else begin
                            qh_do_reg <= 1'b1;
                            qh_reg    <= head_reg;
                        end
                    end
                    state_reg <= ST_WB;
                end
                ST_WB: begin
                    if (qh_do_reg) begin
                        ed_addr_reg <= qh_reg;
                        ed_fld_reg  <= FLD_QPREV;
                        ed_val_reg  <= b_reg;
                        ed_ret_reg  <= ST_DEM0;
                        state_reg   <= ST_ED0;
                    end else begin
                        state_reg <= ST_DEM0;
                    end
                end
                // Demote the bottom LIR block into the queue
                ST_DEM0: begin
                    if (demote_reg) begin
                        t_reg     <= bl_reg;
                        state_reg <= ST_DEM1;
                    end else begin
                        state_reg <= ST_PRUNE;
                    end
                end
                ST_DEM1: begin
                    tr_reg <= rd;
                    if ((head_reg != t_reg) && (rd.qprev == NIL_LINK)) begin
                        state_reg <= ST_DEM2;
                    end else begin
                        u_p_reg    <= rd.qprev;
                        u_n_reg    <= rd.qnext;
                        qu_ret_reg <= ST_DEM2;
                        state_reg  <= ST_QU0;
                    end
                end
                ST_DEM2: begin
                    head_reg <= t_reg;
                    if (head_reg == NIL_LINK) begin
                        tail_reg  <= t_reg;
                        state_reg <= ST_DEM3;
                    end else begin
                        ed_addr_reg <= head_reg;
                        ed_fld_reg  <= FLD_QPREV;
                        ed_val_reg  <= t_reg;
                        ed_ret_reg  <= ST_DEM3;
                        state_reg   <= ST_ED0;
                    end
                end
                ST_DEM3: begin
                    sk_p_reg   <= t_reg;
                    sk_ret_reg <= ST_DEM4;
                    state_reg  <= ST_SK0;
                end
                ST_DEM4: begin
                    if (bl_reg == NIL_LINK) begin
                        bl_reg <= b_reg;
                    end
                    state_reg <= ST_PRUNE;
                end
                // Prune one HIR entry when the stack grows too long
                ST_PRUNE: begin
                    if ((len_reg <= cfg.max_stack_len) || (bl_reg == NIL_LINK)) begin
                        state_reg <= ST_FIN;
                    end else begin
                        t_reg     <= bl_reg;
                        state_reg <= ST_PW0;
                    end
                end
                ST_PW0: begin
                    state_reg <= (t_reg == NIL_LINK) ? ST_FIN : ST_PW1;
                end
                ST_PW1: begin
                    if (!rd.hir) begin
                        t_reg     <= rd.sprev;
                        state_reg <= ST_PW0;
                    end else begin
                        tr_reg <= rd;
                        if (rd.instk && (len_reg != '0)) begin
                            len_reg <= len_reg - 1'b1;
                        end
                        if ((top_reg != t_reg) && (rd.sprev == NIL_LINK)) begin
                            state_reg <= ST_PI0;
                        end else begin
                            v_p_reg    <= rd.sprev;
                            v_n_reg    <= rd.snext;
                            su_ret_reg <= ST_PI0;
                            state_reg  <= ST_SU0;
                        end
                    end
                end
                ST_PI0: state_reg <= ST_PI1;
                ST_PI1: begin
                    pn_reg    <= rd.snext;
                    state_reg <= ST_PI2;
                end
                ST_PI2: begin
                    if (pn_reg == NIL_LINK) begin
                        bottom_reg <= t_reg;
                        state_reg  <= ST_FIN;
                    end else begin
                        ed_addr_reg <= pn_reg;
                        ed_fld_reg  <= FLD_SPREV;
                        ed_val_reg  <= t_reg;
                        ed_ret_reg  <= ST_FIN;
                        state_reg   <= ST_ED0;
                    end
                end
                // Read-modify-write of one link field
                ST_ED0: state_reg <= ST_ED1;
                ST_ED1: state_reg <= ed_ret_reg;
                // Splice a node out of the queue
                ST_QU0: begin
                    if (u_p_reg == NIL_LINK) begin
                        head_reg  <= u_n_reg;
                        state_reg <= ST_QU1;
                    end else begin
                        ed_addr_reg <= u_p_reg;
                        ed_fld_reg  <= FLD_QNEXT;
                        ed_val_reg  <= u_n_reg;
                        ed_ret_reg  <= ST_QU1;
                        state_reg   <= ST_ED0;
                    end
                end
                ST_QU1: begin
                    if (u_n_reg == NIL_LINK) begin
                        tail_reg  <= u_p_reg;
                        state_reg <= qu_ret_reg;
                    end else begin
                        ed_addr_reg <= u_n_reg;
                        ed_fld_reg  <= FLD_QPREV;
                        ed_val_reg  <= u_p_reg;
                        ed_ret_reg  <= qu_ret_reg;
                        state_reg   <= ST_ED0;
                    end
                end
                // Splice a node out of the stack
                ST_SU0: begin
                    if (v_p_reg == NIL_LINK) begin
                        top_reg   <= v_n_reg;
                        state_reg <= ST_SU1;
                    end else begin
                        ed_addr_reg <= v_p_reg;
                        ed_fld_reg  <= FLD_SNEXT;
                        ed_val_reg  <= v_n_reg;
                        ed_ret_reg  <= ST_SU1;
                        state_reg   <= ST_ED0;
                    end
                end
                ST_SU1: begin
                    if (v_n_reg == NIL_LINK) begin
                        bottom_reg <= v_p_reg;
                        state_reg  <= su_ret_reg;
                    end else begin
                        ed_addr_reg <= v_n_reg;
                        ed_fld_reg  <= FLD_SPREV;
                        ed_val_reg  <= v_p_reg;
                        ed_ret_reg  <= su_ret_reg;
                        state_reg   <= ST_ED0;
                    end
                end
                // Walk up past HIR entries, dropping their stack marks
                ST_SK0: begin
                    if (sk_p_reg == NIL_LINK) begin
                        bl_reg    <= NIL_LINK;
                        state_reg <= sk_ret_reg;
                    end else begin
                        state_reg <= ST_SK1;
                    end
                end
                ST_SK1: begin
                    if (rd.hir) begin
                        if (rd.instk && (len_reg != '0)) begin
                            len_reg <= len_reg - 1'b1;
                        end
                        sk_p_reg  <= rd.sprev;
                        state_reg <= ST_SK0;
                    end else begin
                        bl_reg    <= sk_p_reg;
                        state_reg <= sk_ret_reg;
                    end
                end
                // Hold the result until the output stage takes it
                ST_FIN: begin
                    if (res_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_CLEAR;
            endcase
        end
    end

    a_free_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_CLEAR) |-> (free_reg <= cfg.cache_size))
        else $error("free slot count above cache size");

    a_evict_is_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res.evicted_valid) |-> !res.hit)
        else $error("eviction reported on a hit");

    a_evict_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EV1) |-> (free_reg == '0) && (t_reg != NIL_LINK))
        else $error("eviction without a full cache");

    a_wb_marks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WB) |-> ram_we && ram_wdata.res && ram_wdata.instk)
        else $error("referenced block written back without marks");

endmodule
`default_nettype wire

// ----- tb/lirs_cache_replacement_test.sv -----
`timescale 1ns / 100ps
`default_nettype none
module lirs_cache_replacement_test
    import lirs_pkg::*;
();

    localparam int NIL       = NUM_BLOCKS;
    localparam int IDLE_LIMIT = 250000;
    localparam int DRAIN_CYC  = 40;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [16:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;

    lirs_cache_replacement dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Shadow of the replacement state
    int unsigned cache_slots, hir_slots, stack_cap;
    bit blk_res[NUM_BLOCKS];
    bit blk_hir[NUM_BLOCKS];
    bit blk_instk[NUM_BLOCKS];
    int stk_prev[NUM_BLOCKS];
    int stk_next[NUM_BLOCKS];
    int q_prev[NUM_BLOCKS];
    int q_next[NUM_BLOCKS];
    int stk_top, stk_bot, q_head, q_tail, lir_bottom;
    int unsigned free_cnt, lir_cnt, stk_len;
    int prev_blk;

    result_t expected_q[$];
    bit failed = 1'b0;
    bit stim_done = 1'b0;

    function automatic void lirs_clear();
        for (int i = 0; i < NUM_BLOCKS; i++) begin
            blk_res[i] = 0; blk_hir[i] = 1; blk_instk[i] = 0;
            stk_prev[i] = NIL; stk_next[i] = NIL; q_prev[i] = NIL; q_next[i] = NIL;
        end
        stk_top = NIL; stk_bot = NIL; q_head = NIL; q_tail = NIL; lir_bottom = NIL;
        free_cnt = cache_slots; lir_cnt = 0; stk_len = 0; prev_blk = NIL;
    endfunction

    function automatic void mark_out(int x);
        if (blk_instk[x]) begin
            blk_instk[x] = 0;
            if (stk_len > 0) stk_len--;
        end
    endfunction

    // Climb past HIR entries toward the top, dropping their stack marks
    function automatic int climb_to_lir(int p);
        while (p != NIL && blk_hir[p]) begin
            mark_out(p);
            p = stk_prev[p];
        end
        return p;
    endfunction

    function automatic void q_unlink(int x);
        int p, n;
        if (q_head != x && q_prev[x] == NIL) return;
        p = q_prev[x];
        n = q_next[x];
        if (p == NIL) q_head = n; else q_next[p] = n;
        if (n == NIL) q_tail = p; else q_prev[n] = p;
        q_prev[x] = NIL; q_next[x] = NIL;
    endfunction

    function automatic void q_push(int x);
        q_unlink(x);
        q_prev[x] = NIL;
        q_next[x] = q_head;
        if (q_head == NIL) q_tail = x; else q_prev[q_head] = x;
        q_head = x;
    endfunction

    function automatic void stk_unlink(int x);
        int p, n;
        if (stk_top != x && stk_prev[x] == NIL) return;
        if (x == lir_bottom) lir_bottom = climb_to_lir(stk_prev[x]);
        p = stk_prev[x];
        n = stk_next[x];
        if (p == NIL) stk_top = n; else stk_next[p] = n;
        if (n == NIL) stk_bot = p; else stk_prev[n] = p;
        stk_prev[x] = NIL; stk_next[x] = NIL;
    endfunction

    function automatic void stk_push(int x);
        stk_prev[x] = NIL;
        stk_next[x] = stk_top;
        if (stk_top == NIL) stk_bot = x; else stk_prev[stk_top] = x;
        stk_top = x;
    endfunction

    function automatic void stk_insert_below(int x, int a);
        int n;
        n = stk_next[a];
        stk_next[x] = n;
        stk_prev[x] = a;
        if (n != NIL) stk_prev[n] = x; else stk_bot = x;
        stk_next[a] = x;
    endfunction

    // Move the lowest HIR entry above the bottom LIR block below it
    function automatic void stack_trim();
        int t;
        if (stk_len <= stack_cap || lir_bottom == NIL) return;
        t = lir_bottom;
        while (t != NIL && !blk_hir[t]) t = stk_prev[t];
        if (t == NIL) return;
        mark_out(t);
        stk_unlink(t);
        stk_insert_below(t, lir_bottom);
    endfunction

    function automatic void cfg_apply(reg_idx_t idx, int unsigned val);
        case (idx)
            REG_CACHE_SIZE: cache_slots = val & 32'h1FFFF;
            REG_HIR_LIMIT:  hir_slots   = val & 32'hFFFF;
            REG_MAX_STACK:  stack_cap   = val & 32'h1FFFF;
            default: ;
        endcase
        lirs_clear();
    endfunction

    function automatic result_t lirs_reference(int b);
        result_t r;
        int t, d;
        int unsigned lir_cap;
        r = '0;
        if (prev_blk == b) begin
            r.hit = 1'b1;
        end else if (!(!blk_res[b] && free_cnt == 0 && q_tail == NIL)) begin
            prev_blk = b;
            if (!blk_res[b]) begin
                if (free_cnt == 0) begin
                    t = q_tail;
                    blk_res[t] = 0;
                    q_unlink(t);
                    free_cnt++;
                    r.evicted_valid = 1'b1;
                    r.evicted_block = t[15:0];
                end else if (free_cnt > hir_slots) begin
                    blk_hir[b] = 0;
                    lir_cnt++;
                end
                free_cnt--;
            end else begin
                r.hit = 1'b1;
                if (blk_hir[b]) q_unlink(b);
            end
            stk_unlink(b);
            stk_push(b);
            blk_res[b] = 1;
            if (!blk_instk[b]) stk_len++;
            if (lir_bottom == NIL && !blk_hir[b]) lir_bottom = b;
            if (blk_hir[b] && blk_instk[b]) begin
                // promote, demoting the bottom LIR block when over the LIR budget
                blk_hir[b] = 0;
                lir_cnt++;
                lir_cap = cache_slots > hir_slots ? cache_slots - hir_slots : 0;
                if (lir_cnt > lir_cap && lir_bottom != NIL && lir_bottom != b) begin
                    d = lir_bottom;
                    q_push(d);
                    blk_hir[d] = 1;
                    lir_cnt--;
                    lir_bottom = climb_to_lir(d);
                end
                if (lir_bottom == NIL) lir_bottom = b;
            end else if (blk_hir[b]) begin
                q_push(b);
            end
            blk_instk[b] = 1;
            stack_trim();
        end
        r.stack_length = stk_len[16:0];
        r.lir_count    = lir_cnt[16:0];
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Drive one block reference and record its predicted result on acceptance
    task automatic send_block(int b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= b[15:0];
        do @(posedge aclk); while (!s_tready);
        expected_q.push_back(lirs_reference(b));
    endtask

    task automatic hold_input();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    task automatic drain();
        hold_input();
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);
    endtask

    task automatic write_reg(reg_idx_t idx, int unsigned val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val[16:0];
        @(posedge aclk);
        cfg_apply(idx, val);
    endtask

    task automatic configure(int unsigned cs, int unsigned hl, int unsigned ms);
        drain();
        write_reg(REG_CACHE_SIZE, cs);
        write_reg(REG_HIR_LIMIT, hl);
        write_reg(REG_MAX_STACK, ms);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Mostly loops over a hot working set with random content, some noise
    task automatic run_workload(int n, int hot, int base);
        int b, r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 70) b = (base + $urandom_range(0, hot - 1)) & 16'hFFFF;
            else if (r < 85) b = (base + $urandom_range(0, 3 * hot)) & 16'hFFFF;
            else b = $urandom_range(0, 65535);
            send_block(b);
            if ($urandom_range(0, 9) == 0) send_block(b);
        end
    endtask

    task automatic test_directed_defaults();
        int dir_blocks[] = '{0, 65535, 65535, 16'h5555, 16'hAAAA, 0, 1, 2, 1, 0};
        foreach (dir_blocks[i]) send_block(dir_blocks[i]);
    endtask

    task automatic test_small_cache_prune();
        configure(10, 2, 1);
        for (int i = 0; i < 14; i++) send_block(i % 12);
        run_workload(150, 14, $urandom_range(0, 65535));
    endtask

    task automatic test_all_hir();
        configure(10, 65535, 65536);
        run_workload(100, 12, $urandom_range(0, 65535));
        // let every result come back before more stimulus
        drain();
        run_workload(50, 12, 0);
    endtask

    task automatic test_large_cache();
        configure(65536, 1, 65536);
        run_workload(150, 200, $urandom_range(0, 65535));
    endtask

    task automatic test_mid_cache();
        configure(16, 4, 20);
        run_workload(150, 22, $urandom_range(0, 65535));
    endtask

    task automatic test_tight_lir();
        configure(12, 11, 6);
        run_workload(150, 16, 65530);
    endtask

    // Result stall pattern: mostly ready, short stalls, an occasional long one
    int stall_left = 0;
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 99) < 80) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= 1'b0;
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                        : $urandom_range(0, 2);
        end
    end

    // Check each result beat against the oldest prediction
    always @(posedge aclk) begin
        result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.hit           = m_tdata[0];
            got.evicted_valid = m_tdata[1];
            got.evicted_block = m_tdata[17:2];
            got.stack_length  = m_tdata[34:18];
            got.lir_count     = m_tdata[51:35];
            if (expected_q.size() == 0) begin
                $error("result beat with no prediction pending: %h", m_tdata);
                failed = 1'b1;
            end else begin
                want = expected_q.pop_front();
                if (got.hit !== want.hit) begin
                    $error("hit: expected %0d, got %0d", want.hit, got.hit);
                    failed = 1'b1;
                end
                if (got.evicted_valid !== want.evicted_valid) begin
                    $error("evicted_valid: expected %0d, got %0d",
                           want.evicted_valid, got.evicted_valid);
                    failed = 1'b1;
                end
                if (got.evicted_block !== want.evicted_block) begin
                    $error("evicted_block: expected %0d, got %0d",
                           want.evicted_block, got.evicted_block);
                    failed = 1'b1;
                end
                if (got.stack_length !== want.stack_length) begin
                    $error("stack_length: expected %0d, got %0d",
                           want.stack_length, got.stack_length);
                    failed = 1'b1;
                end
                if (got.lir_count !== want.lir_count) begin
                    $error("lir_count: expected %0d, got %0d",
                           want.lir_count, got.lir_count);
                    failed = 1'b1;
                end
            end
        end
    end

    // Abort when neither side moves a beat for too long
    int idle_cycles = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == IDLE_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin
        cache_slots = 1024;
        hir_slots   = 10;
        stack_cap   = 65536;
        lirs_clear();
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_defaults();
        test_small_cache_prune();
        test_all_hir();
        test_large_cache();
        test_mid_cache();
        test_tight_lir();
        drain();

        if (!failed) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ----- sim.f -----
rtl/lirs_pkg.sv
rtl/lirs_ram.sv
rtl/lirs_ctrl.sv
rtl/lirs_cache_replacement.sv
tb/lirs_cache_replacement_test.sv
